// ===== hw/rtl/rskd_pkg.sv =====
// ============================================================================
// rskd_pkg
// Shared types, constants and the control program of the key derivation unit.
// ============================================================================
package rskd_pkg;

  localparam int ModulusBitsDefault = 16;
  localparam int PrimeBits          = 16;
  localparam int ModOutBits         = 16;
  localparam int TotOutBits         = 16;
  localparam int ExpOutBits         = 17;
  localparam int InDataBits         = 32;
  localparam int OutDataBits        = 72;
  localparam int PcBits             = 5;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_PROD      = 4'd1,
    OP_INIT_E    = 4'd2,
    OP_GCD_INIT  = 4'd3,
    OP_DIV_AB    = 4'd4,
    OP_INC_E     = 4'd5,
    OP_DIV_ET    = 4'd6,
    OP_MULQ      = 4'd7,
    OP_SUPD      = 4'd8,
    OP_FIX_NEG   = 4'd9,
    OP_FIX_MOD   = 4'd10,
    OP_FIX_SMALL = 4'd11,
    OP_EMIT_OK   = 4'd12,
    OP_EMIT_REJ  = 4'd13
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT   = 3'd0,
    C_ALWAYS = 3'd1,
    C_REJECT = 3'd2,
    C_BZERO  = 3'd3,
    C_AONE   = 3'd4
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [PcBits-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  localparam logic [PcBits-1:0] StepProd     = 5'd0;
  localparam logic [PcBits-1:0] StepCheck    = 5'd1;
  localparam logic [PcBits-1:0] StepGcdInit  = 5'd2;
  localparam logic [PcBits-1:0] StepGcdTest  = 5'd3;
  localparam logic [PcBits-1:0] StepGcdStep  = 5'd4;
  localparam logic [PcBits-1:0] StepGcdDone  = 5'd5;
  localparam logic [PcBits-1:0] StepNextE    = 5'd6;
  localparam logic [PcBits-1:0] StepInvInit  = 5'd7;
  localparam logic [PcBits-1:0] StepInvTest  = 5'd8;
  localparam logic [PcBits-1:0] StepInvDiv   = 5'd9;
  localparam logic [PcBits-1:0] StepInvMul   = 5'd10;
  localparam logic [PcBits-1:0] StepInvUpd   = 5'd11;
  localparam logic [PcBits-1:0] StepFixNeg   = 5'd12;
  localparam logic [PcBits-1:0] StepFixMod   = 5'd13;
  localparam logic [PcBits-1:0] StepFixSmall = 5'd14;
  localparam logic [PcBits-1:0] StepEmitOk   = 5'd15;
  localparam logic [PcBits-1:0] StepEmitRej  = 5'd16;

  function automatic ctrl_t ucode(input logic [PcBits-1:0] pc);
    ctrl_t w;
    unique case (pc)
      StepProd:     w = '{OP_PROD,      C_NEXT,   StepProd};
      StepCheck:    w = '{OP_INIT_E,    C_REJECT, StepEmitRej};
      StepGcdInit:  w = '{OP_GCD_INIT,  C_NEXT,   StepProd};
      StepGcdTest:  w = '{OP_NOP,       C_BZERO,  StepGcdDone};
      StepGcdStep:  w = '{OP_DIV_AB,    C_ALWAYS, StepGcdTest};
      StepGcdDone:  w = '{OP_NOP,       C_AONE,   StepInvInit};
      StepNextE:    w = '{OP_INC_E,     C_ALWAYS, StepGcdInit};
      StepInvInit:  w = '{OP_DIV_ET,    C_NEXT,   StepProd};
      StepInvTest:  w = '{OP_NOP,       C_BZERO,  StepFixNeg};
      StepInvDiv:   w = '{OP_DIV_AB,    C_NEXT,   StepProd};
      StepInvMul:   w = '{OP_MULQ,      C_NEXT,   StepProd};
      StepInvUpd:   w = '{OP_SUPD,      C_ALWAYS, StepInvTest};
      StepFixNeg:   w = '{OP_FIX_NEG,   C_NEXT,   StepProd};
      StepFixMod:   w = '{OP_FIX_MOD,   C_NEXT,   StepProd};
      StepFixSmall: w = '{OP_FIX_SMALL, C_NEXT,   StepProd};
      StepEmitOk:   w = '{OP_EMIT_OK,   C_NEXT,   StepProd};
      StepEmitRej:  w = '{OP_EMIT_REJ,  C_NEXT,   StepProd};
      default:      w = '{OP_EMIT_REJ,  C_NEXT,   StepProd};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/rskd_div.sv =====
// ============================================================================
// rskd_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
module rskd_div import rskd_pkg::*; #(
  parameter int WIDTH = ModulusBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] quotient_o,
  output logic [WIDTH-1:0] remainder_o,
  output div_status_t      status_o
);

  localparam int CntBits = $clog2(WIDTH + 1);

  logic [WIDTH-1:0]   quo_q, quo_d;
  logic [WIDTH-1:0]   rem_q, rem_d;
  logic [WIDTH-1:0]   dvs_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [WIDTH:0]     shifted;
  logic [WIDTH:0]     diff;
  logic               fits;

  always_comb begin
    shifted = {rem_q, quo_q[WIDTH-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    rem_d   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    quo_d   = {quo_q[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

// ===== hw/rtl/small_rsa_key_derivation_unit.sv =====
// ============================================================================
// small_rsa_key_derivation_unit
// Derives modulus, totient and the smallest public and private exponents.
// ============================================================================
// A request on the slave stream carries the two factors p and q. The block
// takes one request at a time: s_axis_tready is high only while no request
// is in work. Each request yields exactly one result on the master stream,
// with tuser high when the factors are rejected and all data fields zero.
// A short control program steps a datapath with one shared divider that
// yields one quotient bit per cycle. A gcd step is a test step and one
// division, and an inverse step a test step, one division, a multiply and
// an update step. A rejected request runs only the product, check and
// reject steps. The result sits in an output register, so the next request
// can be taken while that result still waits for the receiver; if the
// receiver still stalls when the next request reaches its final step, the
// program waits there. Reset clears the sequencer and the output valid flag
// at once.
// ============================================================================
module small_rsa_key_derivation_unit import rskd_pkg::*; #(
  parameter int MODULUS_BITS = ModulusBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // prime_p [15:0], prime_q [31:16]
  input  logic [InDataBits-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // modulus [15:0], totient_value [31:16], public_exponent [48:32],
  // private_exponent [65:49], zero fill [71:66]
  output logic [OutDataBits-1:0] m_axis_tdata,
  // status [0]
  output logic                   m_axis_tuser
);

  localparam int W = MODULUS_BITS;
  localparam logic [32:0] Limit = 33'd1 << MODULUS_BITS;

  logic                   busy_q;
  logic [PcBits-1:0]      pc_q;
  logic [PrimeBits-1:0]   p_q, q_q;
  logic [31:0]            n_q;
  logic [W-1:0]           t_q, e_q, a_q, b_q, quo_q;
  logic signed [W:0]      s0_q, s1_q;
  logic signed [W+1:0]    prod_q;
  logic                   m_tvalid_q, m_tuser_q;
  logic [OutDataBits-1:0] m_tdata_q;

  ctrl_t                  ctrl;
  logic                   div_op, div_start, emit_op, stall, advance, jump;
  logic [W-1:0]           div_dividend, div_divisor, div_quo, div_rem;
  div_status_t            div_st;
  logic [PrimeBits-1:0]   pm1, qm1;
  logic [31:0]            n_full, t_full;
  logic                   reject;
  logic signed [2*W+1:0]  mul_full;
  logic signed [W+1:0]    s_new;
  logic [OutDataBits-1:0] ok_data;

  assign ctrl    = ucode(pc_q);
  assign div_op  = busy_q && (ctrl.op == OP_DIV_AB || ctrl.op == OP_DIV_ET);
  assign emit_op = busy_q && (ctrl.op == OP_EMIT_OK || ctrl.op == OP_EMIT_REJ);
  assign stall   = (div_op && !div_st.done) || (emit_op && m_tvalid_q && !m_axis_tready);
  assign advance = busy_q && !stall;
  assign div_start = div_op && !div_st.busy && !div_st.done;

  assign div_dividend = (ctrl.op == OP_DIV_ET) ? e_q : a_q;
  assign div_divisor  = (ctrl.op == OP_DIV_ET) ? t_q : b_q;

  rskd_div #(
    .WIDTH(W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .status_o   (div_st)
  );

  always_comb begin
    pm1      = p_q - PrimeBits'(1);
    qm1      = q_q - PrimeBits'(1);
    n_full   = 32'(p_q) * 32'(q_q);
    t_full   = 32'(pm1) * 32'(qm1);
    reject   = (p_q == q_q) || (p_q < PrimeBits'(2)) || (q_q < PrimeBits'(2)) ||
               ({1'b0, n_q} >= Limit);
    mul_full = $signed({1'b0, quo_q}) * s1_q;
    s_new    = {s0_q[W], s0_q} - prod_q;
    ok_data  = {6'd0, ExpOutBits'($unsigned(s0_q)), ExpOutBits'(e_q),
                TotOutBits'(t_q), n_q[ModOutBits-1:0]};
    unique case (ctrl.cond)
      C_NEXT:   jump = 1'b0;
      C_ALWAYS: jump = 1'b1;
      C_REJECT: jump = reject;
      C_BZERO:  jump = (b_q == '0);
      C_AONE:   jump = (a_q == W'(1));
      default:  jump = 1'b0;
    endcase
  end

  assign s_axis_tready = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pc_q       <= StepProd;
      m_tvalid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && !busy_q) begin
        busy_q <= 1'b1;
        pc_q   <= StepProd;
      end else if (advance) begin
        if (emit_op) begin
          busy_q <= 1'b0;
          pc_q   <= StepProd;
        end else if (jump) begin
          pc_q <= ctrl.target;
        end else begin
          pc_q <= pc_q + PcBits'(1);
        end
      end
      if (advance && emit_op) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && !busy_q) begin
      p_q <= s_axis_tdata[PrimeBits-1:0];
      q_q <= s_axis_tdata[2*PrimeBits-1:PrimeBits];
    end
    if (advance) begin
      unique case (ctrl.op)
        OP_NOP: begin
        end
        OP_PROD: begin
          n_q <= n_full;
          t_q <= t_full[W-1:0];
        end
        OP_INIT_E:   e_q <= W'(2);
        OP_GCD_INIT: begin
          a_q <= e_q;
          b_q <= t_q;
        end
        OP_DIV_AB: begin
          a_q   <= b_q;
          b_q   <= div_rem;
          quo_q <= div_quo;
        end
        OP_INC_E: e_q <= e_q + W'(1);
        OP_DIV_ET: begin
          a_q  <= t_q;
          b_q  <= div_rem;
          s0_q <= '0;
          s1_q <= (W+1)'(1);
        end
        OP_MULQ: prod_q <= mul_full[W+1:0];
        OP_SUPD: begin
          s0_q <= s1_q;
          s1_q <= s_new[W:0];
        end
        OP_FIX_NEG: begin
          if (s0_q[W]) s0_q <= s0_q + $signed({1'b0, t_q});
        end
        OP_FIX_MOD: begin
          if (s0_q[W-1:0] >= t_q) s0_q <= s0_q - $signed({1'b0, t_q});
        end
        OP_FIX_SMALL: begin
          if (s0_q[W-1:0] < W'(2)) s0_q <= s0_q + $signed({1'b0, t_q});
        end
        OP_EMIT_OK: begin
          m_tdata_q <= ok_data;
          m_tuser_q <= 1'b0;
        end
        OP_EMIT_REJ: begin
          m_tdata_q <= '0;
          m_tuser_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  a_idle_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pc_q == StepProd)
    else $error("sequencer left its entry step while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> busy_q && pc_q == StepProd)
    else $error("accepted request did not start the program");

  a_div_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> busy_q)
    else $error("divider running without a request in work");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(emit_op))
    else $error("result appeared without an emit step");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("rejected result carries nonzero data");

endmodule

// ===== tb/tb_small_rsa_key_derivation_unit.sv =====
// ============================================================================
// tb_small_rsa_key_derivation_unit
// Self-checking bench: drives factor pairs on the request stream, predicts
// modulus, totient and both exponents, and compares every result in order.
// ============================================================================
module tb_small_rsa_key_derivation_unit;
  import rskd_pkg::*;

  localparam int          NumDirected  = 24;
  localparam int          RandomItems  = 76;
  localparam int          StallLimit   = 50000;
  localparam int          DrainCycles  = 5000;
  localparam logic        StatusValid  = 1'b0;
  localparam logic        StatusReject = 1'b1;

  typedef struct packed {
    logic [ModOutBits-1:0] modulus;
    logic [TotOutBits-1:0] totient;
    logic [ExpOutBits-1:0] pub_exp;
    logic [ExpOutBits-1:0] priv_exp;
    logic                  status;
  } key_set_t;

  typedef struct packed {
    logic [PrimeBits-1:0] p;
    logic [PrimeBits-1:0] q;
    logic                 typed;
    key_set_t             result;
  } stim_row_t;

  localparam key_set_t KeyRejected = '{16'd0, 16'd0, 17'd0, 17'd0, StatusReject};
  localparam key_set_t KeyTwoThree = '{16'd6, 16'd2, 17'd3, 17'd3, StatusValid};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  key_set_t    pending_keys [$];
  int unsigned fail_count   = 0;
  int unsigned sent_count   = 0;
  int unsigned derived_count = 0;
  int unsigned reject_count = 0;
  int unsigned stall_cycles = 0;
  bit          calm         = 1'b0;

  small_rsa_key_derivation_unit #(
    .MODULUS_BITS(ModulusBitsDefault)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic key_set_t derive_keys(input logic [PrimeBits-1:0] p,
                                           input logic [PrimeBits-1:0] q);
    key_set_t          k;
    longint unsigned   n, t, e, a, b, r, d;
    longint            r0, r1, s0, s1, qt, tmp;
    bit                coprime;
    k = KeyRejected;
    n = longint'(p) * longint'(q);
    if (p == q || p < 2 || q < 2 || n >= (64'd1 << ModulusBitsDefault)) begin
      return k;
    end
    t = (longint'(p) - 1) * (longint'(q) - 1);
    e = 1;
    coprime = 1'b0;
    while (!coprime) begin
      e++;
      a = e;
      b = t;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      coprime = (a == 1);
    end
    r0 = longint'(t);
    r1 = longint'(e % t);
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      qt  = r0 / r1;
      tmp = r0 - qt * r1;
      r0  = r1;
      r1  = tmp;
      tmp = s0 - qt * s1;
      s0  = s1;
      s1  = tmp;
    end
    if (s0 < 0) begin
      s0 += longint'(t);
    end
    d = longint'(s0) % t;
    if (d < 2) begin
      d += t;
    end
    k.modulus  = n[ModOutBits-1:0];
    k.totient  = t[TotOutBits-1:0];
    k.pub_exp  = e[ExpOutBits-1:0];
    k.priv_exp = d[ExpOutBits-1:0];
    k.status   = StatusValid;
    return k;
  endfunction

  task automatic offer_factors(input logic [PrimeBits-1:0] p,
                               input logic [PrimeBits-1:0] q,
                               input logic typed, input key_set_t typed_keys);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 25) begin
      gap = $urandom_range(1, 300);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {q, p};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_keys.push_back(typed ? typed_keys : derive_keys(p, q));
    sent_count++;
  endtask

  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_keys.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    key_set_t exp_keys;
    key_set_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.modulus  = m_axis_tdata[15:0];
      got.totient  = m_axis_tdata[31:16];
      got.pub_exp  = m_axis_tdata[48:32];
      got.priv_exp = m_axis_tdata[65:49];
      got.status   = m_axis_tuser;
      if (pending_keys.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        exp_keys = pending_keys.pop_front();
        if (got.status == StatusReject) reject_count++;
        else derived_count++;
        if (got.modulus !== exp_keys.modulus) begin
          $error("modulus: expected %0d, got %0d", exp_keys.modulus, got.modulus);
          fail_count++;
        end
        if (got.totient !== exp_keys.totient) begin
          $error("totient_value: expected %0d, got %0d", exp_keys.totient, got.totient);
          fail_count++;
        end
        if (got.pub_exp !== exp_keys.pub_exp) begin
          $error("public_exponent: expected %0d, got %0d", exp_keys.pub_exp, got.pub_exp);
          fail_count++;
        end
        if (got.priv_exp !== exp_keys.priv_exp) begin
          $error("private_exponent: expected %0d, got %0d", exp_keys.priv_exp,
                 got.priv_exp);
          fail_count++;
        end
        if (got.status !== exp_keys.status) begin
          $error("status: expected %0d, got %0d", exp_keys.status, got.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t            rows [NumDirected];
    logic [PrimeBits-1:0] fp, fq, swap;
    int unsigned          pick, p_top;
    rows = '{
      '{16'd0,     16'd0,     1'b1, KeyRejected},
      '{16'd0,     16'd65535, 1'b1, KeyRejected},
      '{16'd65535, 16'd0,     1'b1, KeyRejected},
      '{16'd1,     16'd3,     1'b1, KeyRejected},
      '{16'd3,     16'd1,     1'b1, KeyRejected},
      '{16'd65535, 16'd65535, 1'b1, KeyRejected},
      '{16'd257,   16'd257,   1'b1, KeyRejected},
      '{16'd256,   16'd257,   1'b1, KeyRejected},
      '{16'd32768, 16'd2,     1'b1, KeyRejected},
      '{16'd2,     16'd32768, 1'b1, KeyRejected},
      '{16'd2,     16'd3,     1'b1, KeyTwoThree},
      '{16'd3,     16'd2,     1'b1, KeyTwoThree},
      '{16'd3,     16'd5,     1'b0, KeyRejected},
      '{16'd5,     16'd7,     1'b0, KeyRejected},
      '{16'd4,     16'd9,     1'b0, KeyRejected},
      '{16'd61,    16'd53,    1'b0, KeyRejected},
      '{16'd31,    16'd1002,  1'b0, KeyRejected},
      '{16'd255,   16'd257,   1'b0, KeyRejected},
      '{16'd2,     16'd32767, 1'b0, KeyRejected},
      '{16'd32767, 16'd2,     1'b0, KeyRejected},
      '{16'd3,     16'd4,     1'b0, KeyRejected},
      '{16'd16,    16'd4097,  1'b0, KeyRejected},
      '{16'd6,     16'd10921, 1'b0, KeyRejected},
      '{16'd65535, 16'd2,     1'b1, KeyRejected}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      offer_factors(rows[i].p, rows[i].q, rows[i].typed, rows[i].result);
    end
    settle_results();

    for (int i = 0; i < RandomItems; i++) begin
      calm = (i >= 30 && i < 60);
      if (i == 50) begin
        settle_results();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        // Pairs of factors of at least two whose product fits the modulus width.
        p_top = $urandom_range(2, 300);
        fp    = PrimeBits'($urandom_range(2, p_top));
        fq    = PrimeBits'($urandom_range(2, 65535 / fp));
        if ($urandom_range(1) == 1) begin
          swap = fp;
          fp   = fq;
          fq   = swap;
        end
      end else if (pick < 82) begin
        fp = (pick < 76) ? PrimeBits'($urandom_range(0, 300)) : PrimeBits'($urandom);
        fq = fp;
      end else begin
        fp = PrimeBits'($urandom);
        fq = PrimeBits'($urandom);
      end
      offer_factors(fp, fq, 1'b0, KeyRejected);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d factor pairs (%0d from the directed table, %0d random).",
             sent_count, NumDirected, RandomItems);
    $display("Compared %0d derived key sets and %0d rejections, %0d mismatches.",
             derived_count, reject_count, fail_count);
    if (fail_count == 0 && pending_keys.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
